@@ sv/iirap_pkg.sv @@
// Shared types, widths and codes for the direct-form-I IIR filter with preload.
package iirap_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 20;
    localparam int SUM_W    = 22;
    localparam int PROD_W   = SUM_W + SAMPLE_W;
    localparam int ACC_W    = 39;
    localparam int FRAC_W   = 16;
    localparam int DIVD_W   = 36;
    localparam int CNT_W    = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [CNT_W-1:0] DIV_N = CNT_W'(DIVD_W);

    localparam logic [REG_IDX_W-1:0] REG_ORDER = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FF0   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FF1   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FF2   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FB1   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FB2   = 3'd5;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 20'sd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_PSUM,
        ST_PMUL,
        ST_PLOAD,
        ST_DIV,
        ST_COMMIT
    } t_state;

    typedef enum logic [2:0] {
        MUL_B0  = 3'd0,
        MUL_B1  = 3'd1,
        MUL_A1  = 3'd2,
        MUL_B2  = 3'd3,
        MUL_A2  = 3'd4,
        MUL_PRE = 3'd5
    } t_mul_sel;

    typedef enum logic [1:0] {
        CM_FILT,
        CM_PRE_OK,
        CM_PRE_ERR
    } t_commit;

    typedef struct packed {
        logic [1:0]               order;
        logic signed [COEF_W-1:0] ff0;
        logic signed [COEF_W-1:0] ff1;
        logic signed [COEF_W-1:0] ff2;
        logic signed [COEF_W-1:0] fb1;
        logic signed [COEF_W-1:0] fb2;
    } t_cfg;

    typedef struct packed {
        logic     load_x;
        logic     clr_acc;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sums_en;
        logic     div_load;
        logic     div_step;
        logic     commit;
        t_commit  kind;
    } t_dp_cmd;

    typedef struct packed {
        logic den_zero;
        logic out_free;
    } t_dp_sts;

endpackage

@@ sv/iirap_ctrl.sv @@
// Control state machine that sequences multiply-accumulate, division and result commit.
module iirap_ctrl
    import iirap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_action,
    input  logic [1:0] i_ord,
    input  t_dp_sts    i_sts,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [2:0]        r_step, n_step;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_commit           r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_cnt   <= '0;
            r_kind  <= CM_FILT;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_cnt      = r_cnt;
        n_kind     = r_kind;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel = t_mul_sel'(r_step);
        o_cmd.kind    = r_kind;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_x  = 1'b1;
                    o_cmd.clr_acc = 1'b1;
                    n_step        = '0;
                    n_state       = i_action ? ST_PSUM : ST_MAC;
                end
            end
            ST_MAC: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == {i_ord, 1'b0}) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_DRAIN: begin
                n_kind  = CM_FILT;
                n_state = ST_COMMIT;
            end
            ST_PSUM: begin
                o_cmd.sums_en = 1'b1;
                n_state       = ST_PMUL;
            end
            ST_PMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PRE;
                n_state       = ST_PLOAD;
            end
            ST_PLOAD: begin
                if (i_sts.den_zero) begin
                    n_kind  = CM_PRE_ERR;
                    n_state = ST_COMMIT;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_cnt          = DIV_N - CNT_W'(1);
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_kind  = CM_PRE_OK;
                    n_state = ST_COMMIT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_commit_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT && i_sts.out_free) |=> r_state == ST_IDLE)
        else $error("commit did not return to idle");

    a_div_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> r_cnt < DIV_N)
        else $error("divider step count out of range");

endmodule

@@ sv/iirap_dp.sv @@
// Datapath: shared multiplier, accumulator, restoring divider, histories and output register.
module iirap_dp
    import iirap_pkg::*;
#(
    parameter int MAX_ORDER = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic [1:0]                i_ord,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  t_dp_cmd                   i_cmd,
    input  logic                      i_out_ready,
    output t_dp_sts                   o_sts,
    output logic                      o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    output logic                      o_out_status
);

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_xh [MAX_ORDER];
    logic signed [SAMPLE_W-1:0] r_yh [MAX_ORDER];
    logic signed [SUM_W-1:0]    r_num, r_den;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_prod_vld;
    logic                       r_prod_sub;
    logic signed [ACC_W-1:0]    r_acc;
    logic [SUM_W-1:0]           r_rem, r_dvs;
    logic [DIVD_W-1:0]          r_quo;
    logic                       r_neg;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_status;

    logic signed [SAMPLE_W-1:0] w_xh1, w_yh1;
    logic signed [SUM_W-1:0]    w_opa;
    logic signed [SAMPLE_W-1:0] w_opb;
    logic signed [SUM_W-1:0]    w_num, w_den;
    logic signed [PROD_W-1:0]   w_prod_abs;
    logic signed [SUM_W-1:0]    w_den_abs;
    logic [SUM_W:0]             w_trial;
    logic signed [ACC_W-1:0]    w_rnd;
    logic signed [ACC_W-FRAC_W-1:0] w_q;
    logic signed [SAMPLE_W-1:0] w_y_filt, w_y_pre, w_y;

    assign w_xh1 = (MAX_ORDER > 1) ? r_xh[MAX_ORDER-1] : '0;
    assign w_yh1 = (MAX_ORDER > 1) ? r_yh[MAX_ORDER-1] : '0;

    always_comb begin
        w_opa = SUM_W'(i_cfg.ff0);
        w_opb = r_x;
        case (i_cmd.mul_sel)
            MUL_B0:  begin w_opa = SUM_W'(i_cfg.ff0); w_opb = r_x;     end
            MUL_B1:  begin w_opa = SUM_W'(i_cfg.ff1); w_opb = r_xh[0]; end
            MUL_A1:  begin w_opa = SUM_W'(i_cfg.fb1); w_opb = r_yh[0]; end
            MUL_B2:  begin w_opa = SUM_W'(i_cfg.ff2); w_opb = w_xh1;   end
            MUL_A2:  begin w_opa = SUM_W'(i_cfg.fb2); w_opb = w_yh1;   end
            MUL_PRE: begin w_opa = r_num;             w_opb = r_x;     end
            default: begin w_opa = '0;                w_opb = '0;      end
        endcase
    end

    always_comb begin
        w_num = SUM_W'(i_cfg.ff0);
        w_den = SUM_W'(COEF_ONE);
        if (i_ord >= 2'd1) begin
            w_num = w_num + SUM_W'(i_cfg.ff1);
            w_den = w_den + SUM_W'(i_cfg.fb1);
        end
        if (i_ord >= 2'd2) begin
            w_num = w_num + SUM_W'(i_cfg.ff2);
            w_den = w_den + SUM_W'(i_cfg.fb2);
        end
    end

    assign w_prod_abs = r_prod[PROD_W-1] ? -r_prod : r_prod;
    assign w_den_abs  = r_den[SUM_W-1] ? -r_den : r_den;
    assign w_trial    = {r_rem, r_quo[DIVD_W-1]} - {1'b0, r_dvs};

    assign w_rnd = r_acc + (r_acc[ACC_W-1] ? ACC_W'(32767) : ACC_W'(32768));
    assign w_q   = w_rnd[ACC_W-1:FRAC_W];

    always_comb begin
        if (w_q > (ACC_W-FRAC_W)'(32767)) begin
            w_y_filt = 16'sh7FFF;
        end else if (w_q < -(ACC_W-FRAC_W)'(32768)) begin
            w_y_filt = 16'sh8000;
        end else begin
            w_y_filt = w_q[SAMPLE_W-1:0];
        end
        if (!r_neg) begin
            w_y_pre = (r_quo > DIVD_W'(32767)) ? 16'sh7FFF : r_quo[SAMPLE_W-1:0];
        end else begin
            w_y_pre = (r_quo > DIVD_W'(32768)) ? 16'sh8000 : -r_quo[SAMPLE_W-1:0];
        end
        w_y = (i_cmd.kind == CM_FILT) ? w_y_filt : w_y_pre;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_sample;
        end
        if (i_cmd.sums_en) begin
            r_num <= w_num;
            r_den <= w_den;
        end
        r_prod     <= w_opa * w_opb;
        r_prod_sub <= (i_cmd.mul_sel == MUL_A1) || (i_cmd.mul_sel == MUL_A2);
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_prod_sub ? r_acc - ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= w_prod_abs[DIVD_W-1:0];
            r_dvs <= w_den_abs;
            r_neg <= r_prod[PROD_W-1] ^ r_den[SUM_W-1];
        end else if (i_cmd.div_step) begin
            if (!w_trial[SUM_W]) begin
                r_rem <= w_trial[SUM_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[SUM_W-2:0], r_quo[DIVD_W-1]};
                r_quo <= {r_quo[DIVD_W-2:0], 1'b0};
            end
        end
        if (i_cmd.commit) begin
            r_out_sample <= (i_cmd.kind == CM_FILT) ? w_y : '0;
            r_out_status <= (i_cmd.kind == CM_PRE_ERR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_xh[k] <= '0;
                r_yh[k] <= '0;
            end
        end else begin
            r_prod_vld <= i_cmd.mul_en;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                case (i_cmd.kind)
                    CM_FILT: begin
                        for (int k = MAX_ORDER - 1; k > 0; k--) begin
                            r_xh[k] <= r_xh[k-1];
                            r_yh[k] <= r_yh[k-1];
                        end
                        r_xh[0] <= r_x;
                        r_yh[0] <= w_y;
                    end
                    CM_PRE_OK: begin
                        for (int k = 0; k < MAX_ORDER; k++) begin
                            r_xh[k] <= r_x;
                            r_yh[k] <= w_y;
                        end
                    end
                    CM_PRE_ERR: begin
                        for (int k = 0; k < MAX_ORDER; k++) begin
                            r_xh[k] <= '0;
                            r_yh[k] <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_sts.den_zero = (r_den == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_sample   = r_out_sample;
    assign o_out_status   = r_out_status;

    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result committed over an untaken beat");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_load |-> (r_den != '0))
        else $error("divider loaded with a zero denominator");

    a_err_zero_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_sample == '0))
        else $error("error beat carries a nonzero sample");

endmodule

@@ sv/iir_arma_filter_with_preload.sv @@
// Top level of the IIR filter with preload: configuration registers, control and datapath.
//
//  channel  | dir | handshake                        | payload
//  ---------+-----+----------------------------------+------------------------------------
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready | tdata: sample; tuser: action
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready | tdata: out_sample; tuser: status
//  cfg      | in  | i_cfg_we                          | i_cfg_idx, i_cfg_data
//
// A filter beat runs its taps through the one shared multiplier, which takes one tap per cycle.
// A preload beat is paced by the one-bit-per-cycle restoring divider, which is skipped
// when the denominator sum is zero.
// One beat is processed at a time; the next is accepted once the result is in the output register.
// Reset is synchronous and active low; it clears control state and histories and returns the
// coefficients to a unity-gain, order-zero filter.
// A stalled output holds its beat; processing waits only at the final commit.
module iir_arma_filter_with_preload
    import iirap_pkg::*;
#(
    parameter int MAX_ORDER = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [15:0]           i_s_axis_tdata,   // [15:0] sample
    input  logic [0:0]            i_s_axis_tuser,   // [0] action
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,   // [15:0] out_sample
    output logic [0:0]            o_m_axis_tuser,   // [0] status
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COEF_W-1:0]     i_cfg_data
);

    t_cfg       r_cfg;
    logic [1:0] w_ord;
    t_dp_cmd    w_cmd;
    t_dp_sts    w_sts;
    logic signed [SAMPLE_W-1:0] w_out_sample;
    logic       w_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.order <= '0;
            r_cfg.ff0   <= COEF_ONE;
            r_cfg.ff1   <= '0;
            r_cfg.ff2   <= '0;
            r_cfg.fb1   <= '0;
            r_cfg.fb2   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORDER: r_cfg.order <= i_cfg_data[1:0];
                REG_FF0:   r_cfg.ff0   <= i_cfg_data;
                REG_FF1:   r_cfg.ff1   <= i_cfg_data;
                REG_FF2:   r_cfg.ff2   <= i_cfg_data;
                REG_FB1:   r_cfg.fb1   <= i_cfg_data;
                REG_FB2:   r_cfg.fb2   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_ord = (r_cfg.order > 2'(MAX_ORDER)) ? 2'(MAX_ORDER) : r_cfg.order;

    iirap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_action   (i_s_axis_tuser[0]),
        .i_ord      (w_ord),
        .i_sts      (w_sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    iirap_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_ord        (w_ord),
        .i_sample     (i_s_axis_tdata),
        .i_cmd        (w_cmd),
        .i_out_ready  (i_m_axis_tready),
        .o_sts        (w_sts),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_sample (w_out_sample),
        .o_out_status (w_out_status)
    );

    assign o_m_axis_tdata = w_out_sample;
    assign o_m_axis_tuser = w_out_status;

endmodule

@@ tb/sv/iirap_tb_pkg.sv @@
// Action and status codes shared by the filter testbench and its checker.
package iirap_tb_pkg;

    localparam logic ACT_FILTER  = 1'b0;
    localparam logic ACT_PRELOAD = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DEN_ZERO = 1'b1;

    localparam int HIST_DEPTH = 2;

endpackage

@@ tb/sv/iir_response_checker.sv @@
// Checker that predicts every filter and preload result and compares it with the output beats.
module iir_response_checker
    import iirap_pkg::*;
    import iirap_tb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [15:0]          i_in_data,
    input  logic [0:0]           i_in_user,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [15:0]          i_out_data,
    input  logic [0:0]           i_out_user,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       status;
    } t_filter_result;

    logic [1:0]                 order_q;
    logic signed [COEF_W-1:0]   ff_coef_q [3];
    logic signed [COEF_W-1:0]   fb_coef_q [3];
    logic signed [SAMPLE_W-1:0] x_hist [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] y_hist [HIST_DEPTH];
    t_filter_result             expected_results [$];
    int                         error_count   = 0;
    int                         pending_count = 0;
    int                         result_count  = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    function automatic logic signed [SAMPLE_W-1:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return SAMPLE_W'(v);
    endfunction

    // Rounds a Q.16 value to the nearest integer, with ties away from zero.
    function automatic longint round_q16(input longint acc);
        if (acc >= 0) begin
            return (acc + 32768) / 65536;
        end
        return -((-acc + 32768) / 65536);
    endfunction

    task automatic reset_model();
        order_q = 2'd0;
        for (int k = 0; k < 3; k++) begin
            ff_coef_q[k] = '0;
            fb_coef_q[k] = '0;
        end
        ff_coef_q[0] = COEF_ONE;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            x_hist[k] = '0;
            y_hist[k] = '0;
        end
    endtask

    task automatic predict_beat(input logic act, input logic signed [SAMPLE_W-1:0] x);
        int                         taps;
        longint                     acc;
        longint                     numsum;
        longint                     densum;
        logic signed [SAMPLE_W-1:0] y;
        t_filter_result             res;
        taps = (order_q > 2'd2) ? HIST_DEPTH : int'(order_q);
        if (act == ACT_FILTER) begin
            acc = longint'(ff_coef_q[0]) * longint'(x);
            for (int k = 1; k <= taps; k++) begin
                acc += longint'(ff_coef_q[k]) * longint'(x_hist[k-1]);
                acc -= longint'(fb_coef_q[k]) * longint'(y_hist[k-1]);
            end
            y = clip16(round_q16(acc));
            for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                x_hist[k] = x_hist[k-1];
                y_hist[k] = y_hist[k-1];
            end
            x_hist[0] = x;
            y_hist[0] = y;
            res.out_sample = y;
            res.status     = STATUS_OK;
        end else begin
            numsum = longint'(ff_coef_q[0]);
            densum = 65536;
            for (int k = 1; k <= taps; k++) begin
                numsum += longint'(ff_coef_q[k]);
                densum += longint'(fb_coef_q[k]);
            end
            if (densum == 0) begin
                y = '0;
                res.status = STATUS_DEN_ZERO;
            end else begin
                y = clip16((longint'(x) * numsum) / densum);
                res.status = STATUS_OK;
            end
            for (int k = 0; k < HIST_DEPTH; k++) begin
                x_hist[k] = (densum == 0) ? '0 : x;
                y_hist[k] = y;
            end
            res.out_sample = '0;
        end
        expected_results.push_back(res);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch on result beat %0d: %s", result_count, what);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_filter_result want;
        if (!i_rst_n) begin
            reset_model();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ORDER: order_q      = i_cfg_data[1:0];
                    REG_FF0:   ff_coef_q[0] = i_cfg_data;
                    REG_FF1:   ff_coef_q[1] = i_cfg_data;
                    REG_FF2:   ff_coef_q[2] = i_cfg_data;
                    REG_FB1:   fb_coef_q[1] = i_cfg_data;
                    REG_FB2:   fb_coef_q[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with no expectation pending");
                end else begin
                    want = expected_results.pop_front();
                    if ($signed(i_out_data) !== $signed(want.out_sample)) begin
                        report_mismatch($sformatf("out_sample %0d, expected %0d",
                                                  $signed(i_out_data),
                                                  $signed(want.out_sample)));
                    end
                    if (i_out_user[0] !== want.status) begin
                        report_mismatch($sformatf("status %b, expected %b",
                                                  i_out_user[0], want.status));
                    end
                end
                result_count++;
            end
            if (i_in_valid && i_in_ready) begin
                predict_beat(i_in_user[0], i_in_data);
            end
        end
        pending_count = expected_results.size();
    end

endmodule

@@ tb/sv/iir_arma_filter_with_preload_test.sv @@
// Testbench top for the IIR filter with preload: clock, reset, stimulus and verdict.
module iir_arma_filter_with_preload_test;
    import iirap_pkg::*;
    import iirap_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 48;
    localparam int RANDOM_PHASES   = 12;
    localparam int BEATS_PER_PHASE = 90;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata   = '0;
    logic [0:0]           s_axis_tuser   = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b1;
    logic [15:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 cfg_we         = 1'b0;
    logic [REG_IDX_W-1:0] cfg_idx        = '0;
    logic [COEF_W-1:0]    cfg_data       = '0;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_cycles        = 0;
    int cycle_count        = 0;
    int errors;
    int pending;

    iir_arma_filter_with_preload u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    iir_response_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // A pending hold-off keeps the output stalled regardless of the stall rate.
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    task automatic send_beat(input logic act, input logic signed [SAMPLE_W-1:0] x);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tuser  <= act;
        do begin
            @(posedge clk);
        end while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic load_coefficients(input t_cfg c);
        write_reg(REG_ORDER, COEF_W'(c.order));
        write_reg(REG_FF0, c.ff0);
        write_reg(REG_FF1, c.ff1);
        write_reg(REG_FF2, c.ff2);
        write_reg(REG_FB1, c.fb1);
        write_reg(REG_FB2, c.fb2);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [COEF_W-1:0] random_coef();
        case ($urandom_range(7, 0))
            0:       return 20'sh7FFFF;
            1:       return 20'sh80000;
            2, 3:    return COEF_W'($urandom);
            default: return COEF_W'($urandom_range(131072, 0)) - 20'sd65536;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9, 0))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return SAMPLE_W'($urandom);
            default: return SAMPLE_W'($urandom_range(2000, 0)) - 16'sd1000;
        endcase
    endfunction

    initial begin
        t_cfg cfg;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset the filter is order zero with unity gain.
        send_beat(ACT_FILTER, 16'sh7FFF);
        send_beat(ACT_FILTER, 16'sh8000);
        send_beat(ACT_FILTER, 16'sd0);
        send_beat(ACT_PRELOAD, 16'sd100);
        send_beat(ACT_FILTER, -16'sd1);
        wait_until_idle();

        // Half gain puts odd samples exactly on a rounding tie.
        cfg = '{order: 2'd0, ff0: 20'sd32768, ff1: '0, ff2: '0, fb1: '0, fb2: '0};
        load_coefficients(cfg);
        send_beat(ACT_FILTER, 16'sd1);
        send_beat(ACT_FILTER, -16'sd1);
        send_beat(ACT_FILTER, 16'sd3);
        send_beat(ACT_FILTER, -16'sd3);
        send_beat(ACT_PRELOAD, 16'sh8000);
        wait_until_idle();

        // Order register above the maximum, every coefficient at an extreme.
        cfg = '{order: 2'd3, ff0: 20'sh7FFFF, ff1: 20'sh80000, ff2: 20'sh7FFFF,
                fb1: 20'sh80000, fb2: 20'sh7FFFF};
        load_coefficients(cfg);
        send_beat(ACT_FILTER, 16'sh7FFF);
        send_beat(ACT_FILTER, 16'sh8000);
        send_beat(ACT_FILTER, 16'sh7FFF);
        send_beat(ACT_PRELOAD, 16'sh7FFF);
        send_beat(ACT_FILTER, 16'sd1);
        wait_until_idle();

        // The denominator sum is zero at order one.
        cfg = '{order: 2'd1, ff0: 20'sd65536, ff1: 20'sd12345, ff2: '0,
                fb1: -20'sd65536, fb2: 20'sd5000};
        load_coefficients(cfg);
        send_beat(ACT_PRELOAD, 16'sd1234);
        send_beat(ACT_FILTER, 16'sd500);
        send_beat(ACT_FILTER, -16'sd700);
        wait_until_idle();

        // The denominator sum is zero at order two.
        cfg = '{order: 2'd2, ff0: 20'sd40000, ff1: -20'sd20000, ff2: 20'sd9000,
                fb1: -20'sd32768, fb2: -20'sd32768};
        load_coefficients(cfg);
        send_beat(ACT_FILTER, 16'sd1000);
        send_beat(ACT_PRELOAD, -16'sd5);
        send_beat(ACT_FILTER, 16'sd7);
        wait_until_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            cfg.order = 2'($urandom_range(3, 0));
            cfg.ff0   = random_coef();
            cfg.ff1   = random_coef();
            cfg.ff2   = random_coef();
            cfg.fb1   = random_coef();
            cfg.fb2   = random_coef();
            if (phase % 3 == 2 && cfg.order != 2'd0) begin
                cfg.fb2 = COEF_W'($urandom_range(200000, 0)) - 20'sd100000;
                cfg.fb1 = (cfg.order == 2'd1) ? -20'sd65536 : -20'sd65536 - cfg.fb2;
            end
            load_coefficients(cfg);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
                default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (phase == 0 && n == 10) begin
                    hold_cycles = 400;
                end
                send_beat(($urandom_range(99, 0) < 8) ? ACT_PRELOAD : ACT_FILTER,
                          random_sample());
            end
            wait_until_idle();
        end

        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/iirap_pkg.sv
sv/iirap_ctrl.sv
sv/iirap_dp.sv
sv/iir_arma_filter_with_preload.sv
tb/sv/iirap_tb_pkg.sv
tb/sv/iir_response_checker.sv
tb/sv/iir_arma_filter_with_preload_test.sv
